// ===== rtl/core/sfd_pkg.sv =====
// Shared types and constants of the symmetric FIR decimator.
`timescale 1ns / 1ps

package sfd_pkg;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_MODE       = 2'd0,
        CFG_HALF_TAPS  = 2'd1,
        CFG_COEFS_LOW  = 2'd2,
        CFG_COEFS_HIGH = 2'd3
    } t_cfg_idx;

    // Mode codes; the unused top code behaves as the even decimating mode
    localparam logic [1:0] MODE_FULL_ODD = 2'd0;
    localparam logic [1:0] MODE_DEC_ODD  = 2'd1;
    localparam logic [1:0] MODE_DEC_EVEN = 2'd2;

    localparam int MODE_W      = 2;
    localparam int HALF_W      = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int COEF_W      = 16;
    localparam int COEF_COUNT  = 8;
    localparam int FRAC_BITS   = 14;
    localparam int ROUND_BIAS  = 8192;
    localparam int POS_W       = 13;
    localparam logic [POS_W-1:0] POS_MAX = 13'd8191;
    localparam int IDX_W       = 12;

    // Queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;
    localparam int Q_CW    = 3;

    typedef struct packed {
        logic [IDX_W-1:0] out_index;
        logic             last_of_row;
    } t_tag;

    typedef struct packed {
        logic            full;
        logic [Q_CW-1:0] count;
    } t_q_status;

endpackage

// ===== rtl/core/sfd_front.sv =====
// Front end: sample window, row bookkeeping, result selection and pre-adds.
`timescale 1ns / 1ps

module sfd_front #(
    parameter int MAX_HALF    = 7,
    parameter int SAMPLE_BITS = 16,
    parameter int MAX_ROW     = 4096
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_accept,
    input  logic signed [SAMPLE_BITS-1:0]              i_sample,
    input  logic                                       i_row_end,
    input  logic [sfd_pkg::MODE_W-1:0]                 i_mode,
    input  logic [sfd_pkg::HALF_W-1:0]                 i_half_taps,
    output logic                                       o_push,
    output sfd_pkg::t_tag                              o_tag,
    output logic [(MAX_HALF+1)*(SAMPLE_BITS+1)-1:0]    o_pairs
);

    localparam int WIN    = 2 * MAX_HALF + 1;
    localparam int IW     = $clog2(WIN);
    localparam int HW     = $clog2(MAX_HALF + 1);
    localparam int LANES  = MAX_HALF + 1;
    localparam int PAIR_W = SAMPLE_BITS + 1;
    localparam int PW     = sfd_pkg::POS_W;

    logic signed [SAMPLE_BITS-1:0] r_win [WIN-1];
    logic signed [SAMPLE_BITS-1:0] w_nw  [WIN];
    logic [PW-1:0]                 r_pos;
    logic [PW-1:0]                 n_pos;
    logic [sfd_pkg::IDX_W-1:0]     r_count;
    logic [sfd_pkg::IDX_W-1:0]     n_count;

    logic [HW-1:0] w_h;
    logic          w_even;
    logic          w_decim;
    logic [PW-1:0] w_span;
    logic [PW-1:0] w_pos_next;
    logic [PW-1:0] w_idx;
    logic          w_fits;
    logic          w_in_row;
    logic          w_keep;

    logic signed [PAIR_W-1:0] w_pair [LANES];

    assign w_h = (int'(i_half_taps) > MAX_HALF) ? HW'(MAX_HALF) : HW'(i_half_taps);
    assign w_even  = (i_mode >= sfd_pkg::MODE_DEC_EVEN);
    assign w_decim = (i_mode != sfd_pkg::MODE_FULL_ODD);

    always_comb begin
        if (w_even) begin
            w_span = (w_h == '0) ? PW'(1) : (PW'(w_h) << 1);
        end else begin
            w_span = (PW'(w_h) << 1) + PW'(1);
        end
    end

    assign w_pos_next = (r_pos < sfd_pkg::POS_MAX) ? r_pos + PW'(1) : r_pos;
    assign w_idx      = w_pos_next - w_span;
    assign w_fits     = (w_pos_next >= w_span);
    assign w_in_row   = ({1'b0, w_idx} < (PW+1)'(MAX_ROW));
    assign w_keep     = !w_decim || !w_idx[0];

    assign o_push            = i_accept && w_fits && w_in_row && w_keep;
    assign o_tag.out_index   = r_count;
    assign o_tag.last_of_row = i_row_end;

    // Window as it stands once the new sample is shifted in
    always_comb begin
        w_nw[0] = i_sample;
        for (int j = 1; j < WIN; j++) begin
            w_nw[j] = r_win[j-1];
        end
    end

    // Centre lane: odd kernels only
    assign w_pair[0] = w_even ? '0 : PAIR_W'(w_nw[IW'(w_h)]);

    for (genvar l = 1; l < LANES; l++) begin : g_pair
        logic [IW-1:0] a_idx;
        logic [IW-1:0] b_idx;
        assign a_idx = IW'(int'(w_h) - l);
        assign b_idx = IW'(int'(w_h) + l - (w_even ? 1 : 0));
        always_comb begin
            if (int'(w_h) < l) begin
                w_pair[l] = '0;
            end else begin
                w_pair[l] = PAIR_W'(w_nw[a_idx]) + PAIR_W'(w_nw[b_idx]);
            end
        end
    end

    for (genvar l = 0; l < LANES; l++) begin : g_flat
        assign o_pairs[l*PAIR_W +: PAIR_W] = w_pair[l];
    end

    always_comb begin
        n_pos   = r_pos;
        n_count = r_count;
        if (i_accept) begin
            n_pos = w_pos_next;
            if (o_push) begin
                n_count = r_count + sfd_pkg::IDX_W'(1);
            end
            if (i_row_end) begin
                n_pos   = '0;
                n_count = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_count <= '0;
            for (int j = 0; j < WIN - 1; j++) begin
                r_win[j] <= '0;
            end
        end else begin
            r_pos   <= n_pos;
            r_count <= n_count;
            if (i_accept) begin
                for (int j = 0; j < WIN - 1; j++) begin
                    r_win[j] <= w_nw[j];
                end
            end
        end
    end

endmodule

// ===== rtl/core/sfd_queue.sv =====
// Short queue of pending results between front and back.
`timescale 1ns / 1ps

module sfd_queue #(
    parameter int W = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  logic [W-1:0]          i_data,
    input  logic                  i_pop,
    output logic                  o_valid,
    output logic [W-1:0]          o_data,
    output sfd_pkg::t_q_status    o_status
);

    logic [W-1:0]              r_mem [sfd_pkg::Q_DEPTH];
    logic [sfd_pkg::Q_AW-1:0]  r_rd;
    logic [sfd_pkg::Q_AW-1:0]  r_wr;
    logic [sfd_pkg::Q_CW-1:0]  r_cnt;

    assign o_valid         = (r_cnt != '0);
    assign o_data          = r_mem[r_rd];
    assign o_status.count  = r_cnt;
    assign o_status.full   = (r_cnt == sfd_pkg::Q_CW'(sfd_pkg::Q_DEPTH));

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd  <= '0;
            r_wr  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + sfd_pkg::Q_AW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + sfd_pkg::Q_AW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + sfd_pkg::Q_CW'(1);
                2'b01:   r_cnt <= r_cnt - sfd_pkg::Q_CW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== rtl/core/sfd_back.sv =====
// Back end: tap multiplies, registered sum, rounding, saturation, output word.
`timescale 1ns / 1ps

module sfd_back #(
    parameter int MAX_HALF    = 7,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_valid,
    input  sfd_pkg::t_tag                              i_tag,
    input  logic [(MAX_HALF+1)*(SAMPLE_BITS+1)-1:0]    i_pairs,
    input  logic [2*sfd_pkg::CFG_DATA_W-1:0]           i_coefs,
    input  logic                                       i_out_stall,
    output logic                                       o_pop,
    output logic                                       o_out_valid,
    output logic signed [SAMPLE_BITS-1:0]              o_filtered,
    output logic [sfd_pkg::IDX_W-1:0]                  o_out_index,
    output logic                                       o_last_of_row
);

    localparam int LANES  = MAX_HALF + 1;
    localparam int PAIR_W = SAMPLE_BITS + 1;
    localparam int CW     = sfd_pkg::COEF_W;
    localparam int PROD_W = PAIR_W + CW;
    localparam int ACC_W  = PROD_W + $clog2(LANES) + 2;
    localparam int LO_N   = (LANES + 1) / 2;
    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((1 << (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

    logic w_en;

    logic                     r_a_valid;
    sfd_pkg::t_tag            r_a_tag;
    logic signed [PROD_W-1:0] r_prod [LANES];

    logic                     r_b_valid;
    sfd_pkg::t_tag            r_b_tag;
    logic signed [ACC_W-1:0]  r_sum_lo;
    logic signed [ACC_W-1:0]  r_sum_hi;
    logic signed [ACC_W-1:0]  w_sum_lo;
    logic signed [ACC_W-1:0]  w_sum_hi;

    logic signed [ACC_W-1:0]  w_total;
    logic signed [ACC_W-1:0]  w_shift;
    logic signed [SAMPLE_BITS-1:0] w_sat;

    logic                     r_out_valid;

    // Whole pipeline advances unless the output word is held
    assign w_en  = !(r_out_valid && i_out_stall);
    assign o_pop = w_en && i_valid;

    for (genvar l = 0; l < LANES; l++) begin : g_lane
        logic signed [PAIR_W-1:0] pair;
        logic signed [CW-1:0]     coef;
        assign pair = i_pairs[l*PAIR_W +: PAIR_W];
        if (l < sfd_pkg::COEF_COUNT) begin : g_coef
            assign coef = i_coefs[l*CW +: CW];
        end else begin : g_zero
            assign coef = '0;
        end
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_prod[l] <= pair * coef;
            end
        end
    end

    always_comb begin
        w_sum_lo = '0;
        w_sum_hi = '0;
        for (int l = 0; l < LANES; l++) begin
            if (l < LO_N) begin
                w_sum_lo = w_sum_lo + ACC_W'(r_prod[l]);
            end else begin
                w_sum_hi = w_sum_hi + ACC_W'(r_prod[l]);
            end
        end
    end

    // Round half up, then floor shift
    assign w_total = r_sum_lo + r_sum_hi + ACC_W'(sfd_pkg::ROUND_BIAS);
    assign w_shift = w_total >>> sfd_pkg::FRAC_BITS;

    always_comb begin
        if (w_shift > SAT_HI) begin
            w_sat = SAT_HI[SAMPLE_BITS-1:0];
        end else if (w_shift < SAT_LO) begin
            w_sat = SAT_LO[SAMPLE_BITS-1:0];
        end else begin
            w_sat = w_shift[SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_tag       <= i_tag;
            r_b_tag       <= r_a_tag;
            r_sum_lo      <= w_sum_lo;
            r_sum_hi      <= w_sum_hi;
            o_filtered    <= w_sat;
            o_out_index   <= r_b_tag.out_index;
            o_last_of_row <= r_b_tag.last_of_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_b_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_a_valid   <= i_valid;
            r_b_valid   <= r_a_valid;
            r_out_valid <= r_b_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== rtl/core/symmetric_fir_decimator.sv =====
// Symmetric FIR row filter with optional decimation by two: top level.
// Throughput: one sample word per clock while the queue is not full; sample words
// are still accepted while output words wait, until the queue fills. A result word
// passes the queue register, product register, sum register and output register.
// Reset (synchronous, active low) clears window, row counters, queue and
// pipeline valids; registers return to mode 0, half_taps 1, coefs zero.
`timescale 1ns / 1ps

module symmetric_fir_decimator #(
    parameter int MAX_HALF    = 7,
    parameter int SAMPLE_BITS = 16,
    parameter int MAX_ROW     = 4096
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // sample words
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [SAMPLE_BITS-1:0]       i_sample,
    input  logic                                i_row_end,
    // result words
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [SAMPLE_BITS-1:0]       o_filtered,
    output logic [sfd_pkg::IDX_W-1:0]           o_out_index,
    output logic                                o_last_of_row,
    // configuration writes
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [1:0]                          i_cfg_index,
    input  logic [sfd_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int LANES  = MAX_HALF + 1;
    localparam int PAIR_W = SAMPLE_BITS + 1;
    localparam int DATA_W = LANES * PAIR_W;
    localparam int TAG_W  = $bits(sfd_pkg::t_tag);
    localparam int Q_W    = TAG_W + DATA_W;

    logic [sfd_pkg::MODE_W-1:0]      r_mode;
    logic [sfd_pkg::HALF_W-1:0]      r_half_taps;
    logic [sfd_pkg::CFG_DATA_W-1:0]  r_coefs_low;
    logic [sfd_pkg::CFG_DATA_W-1:0]  r_coefs_high;

    logic                  w_accept;
    logic                  w_push;
    logic                  w_pop;
    sfd_pkg::t_tag         w_front_tag;
    logic [DATA_W-1:0]     w_front_pairs;
    logic                  w_q_valid;
    logic [Q_W-1:0]        w_q_out;
    sfd_pkg::t_q_status    w_qst;
    sfd_pkg::t_tag         w_back_tag;
    logic [DATA_W-1:0]     w_back_pairs;
    sfd_pkg::t_cfg_idx     w_cfg_idx;

    // Configuration is always taken; the host only writes while idle
    assign o_cfg_ready = 1'b1;
    assign w_cfg_idx   = sfd_pkg::t_cfg_idx'(i_cfg_index);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= sfd_pkg::MODE_FULL_ODD;
            r_half_taps  <= sfd_pkg::HALF_W'(1);
            r_coefs_low  <= '0;
            r_coefs_high <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (w_cfg_idx)
                sfd_pkg::CFG_MODE:       r_mode       <= i_cfg_data[sfd_pkg::MODE_W-1:0];
                sfd_pkg::CFG_HALF_TAPS:  r_half_taps  <= i_cfg_data[sfd_pkg::HALF_W-1:0];
                sfd_pkg::CFG_COEFS_LOW:  r_coefs_low  <= i_cfg_data;
                sfd_pkg::CFG_COEFS_HIGH: r_coefs_high <= i_cfg_data;
                default:                 r_mode       <= r_mode;
            endcase
        end
    end

    // Hold samples off only when the queue has no room; a sample that
    // yields no result would not need a slot, but the stall stays simple.
    assign o_in_stall = w_qst.full;
    assign w_accept   = i_in_valid && !o_in_stall;

    // Front: shift the window, count row position, pick centres, pre-add
    sfd_front #(
        .MAX_HALF    (MAX_HALF),
        .SAMPLE_BITS (SAMPLE_BITS),
        .MAX_ROW     (MAX_ROW)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_sample    (i_sample),
        .i_row_end   (i_row_end),
        .i_mode      (r_mode),
        .i_half_taps (r_half_taps),
        .o_push      (w_push),
        .o_tag       (w_front_tag),
        .o_pairs     (w_front_pairs)
    );

    // Queue decouples the front from output back-pressure
    sfd_queue #(
        .W (Q_W)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_data   ({w_front_tag, w_front_pairs}),
        .i_pop    (w_pop),
        .o_valid  (w_q_valid),
        .o_data   (w_q_out),
        .o_status (w_qst)
    );

    assign w_back_tag   = sfd_pkg::t_tag'(w_q_out[Q_W-1 -: TAG_W]);
    assign w_back_pairs = w_q_out[DATA_W-1:0];

    // Back: multiply by coefficients, sum, round, saturate, drive result word
    sfd_back #(
        .MAX_HALF    (MAX_HALF),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (w_q_valid),
        .i_tag         (w_back_tag),
        .i_pairs       (w_back_pairs),
        .i_coefs       ({r_coefs_high, r_coefs_low}),
        .i_out_stall   (i_out_stall),
        .o_pop         (w_pop),
        .o_out_valid   (o_out_valid),
        .o_filtered    (o_filtered),
        .o_out_index   (o_out_index),
        .o_last_of_row (o_last_of_row)
    );

    // A result is never pushed into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_qst.full)
        else $error("queue push while full");

    // The back end only pops words that are there
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> (w_qst.count != '0))
        else $error("queue pop while empty");

    // Fill level tracks a lone push
    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=>
            (w_qst.count == $past(w_qst.count) + sfd_pkg::Q_CW'(1)))
        else $error("queue count did not advance on push");

endmodule
